// File: rtl/dnsqp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnsqp_pkg;

   // One input transaction: a message byte and its start marker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_message;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic [3:0]  field_kind;
      logic [15:0] field_value;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_LENGTH = 3'd1,
      PH_LABEL  = 3'd2,
      PH_QTYPE  = 3'd3,
      PH_QCLASS = 3'd4,
      PH_IDLE   = 3'd5
   } phase_type;

   localparam logic [3:0] KIND_ID        = 4'd0;
   localparam logic [3:0] KIND_FLAGS     = 4'd1;
   localparam logic [3:0] KIND_QD_COUNT  = 4'd2;
   localparam logic [3:0] KIND_AN_COUNT  = 4'd3;
   localparam logic [3:0] KIND_NS_COUNT  = 4'd4;
   localparam logic [3:0] KIND_AR_COUNT  = 4'd5;
   localparam logic [3:0] KIND_NAME_CHAR = 4'd6;
   localparam logic [3:0] KIND_NAME_END  = 4'd7;
   localparam logic [3:0] KIND_QTYPE     = 4'd8;
   localparam logic [3:0] KIND_QCLASS    = 4'd9;

   localparam logic [3:0]  HEADER_LAST_INDEX = 4'd11;
   localparam logic [7:0]  DOT_CHAR          = 8'h2E;
   localparam logic [15:0] NAME_LENGTH_MAX   = 16'hFFFF;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  byte_index;
      logic [7:0]  held_high_byte;
      logic [7:0]  label_bytes_left;
      logic        first_label;
      logic [15:0] name_section_length;
      logic        question_present;
   } parse_state_type;

   localparam parse_state_type STATE_RESTART = '{
      phase:               PH_HEADER,
      byte_index:          4'd0,
      held_high_byte:      8'd0,
      label_bytes_left:    8'd0,
      first_label:         1'b1,
      name_section_length: 16'd0,
      question_present:    1'b0
   };

endpackage

`default_nettype wire

// File: rtl/dnsqp_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Next parse state and optional result for one accepted byte.
module dnsqp_step (
   input  dnsqp_pkg::parse_state_type state_cur,
   input  dnsqp_pkg::req_type         req,
   output dnsqp_pkg::parse_state_type state_next,
   output logic                       emit,
   output dnsqp_pkg::rsp_type         rsp
);

   dnsqp_pkg::parse_state_type cur;
   dnsqp_pkg::parse_state_type nxt;
   logic [15:0] word;
   logic [15:0] length_inc;

   // A start marker restarts the parse before the byte itself is taken.
   assign cur  = req.start_of_message ? dnsqp_pkg::STATE_RESTART : state_cur;
   assign word = {cur.held_high_byte, req.data_byte};
   assign length_inc = (cur.name_section_length == dnsqp_pkg::NAME_LENGTH_MAX) ?
                       cur.name_section_length : cur.name_section_length + 16'd1;

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      rsp  = '0;
      unique case (cur.phase)
         dnsqp_pkg::PH_HEADER: begin
            if (!cur.byte_index[0]) begin
               nxt.held_high_byte = req.data_byte;
               nxt.byte_index     = cur.byte_index + 4'd1;
            end else begin
               rsp.field_kind  = {1'b0, cur.byte_index[3:1]};
               rsp.field_value = word;
               emit            = 1'b1;
               if (rsp.field_kind == dnsqp_pkg::KIND_QD_COUNT) begin
                  nxt.question_present = (word != 16'd0);
               end
               if (cur.byte_index >= dnsqp_pkg::HEADER_LAST_INDEX) begin
                  nxt.byte_index = 4'd0;
                  nxt.phase = nxt.question_present ? dnsqp_pkg::PH_LENGTH
                                                   : dnsqp_pkg::PH_IDLE;
               end else begin
                  nxt.byte_index = cur.byte_index + 4'd1;
               end
            end
         end
         dnsqp_pkg::PH_LENGTH: begin
            nxt.name_section_length = length_inc;
            if (req.data_byte == 8'd0) begin
               nxt.phase       = dnsqp_pkg::PH_QTYPE;
               nxt.byte_index  = 4'd0;
               rsp.field_kind  = dnsqp_pkg::KIND_NAME_END;
               rsp.field_value = length_inc;
               emit            = 1'b1;
            end else begin
               nxt.label_bytes_left = req.data_byte;
               nxt.phase            = dnsqp_pkg::PH_LABEL;
               if (cur.first_label) begin
                  nxt.first_label = 1'b0;
               end else begin
                  rsp.field_kind  = dnsqp_pkg::KIND_NAME_CHAR;
                  rsp.field_value = {8'h00, dnsqp_pkg::DOT_CHAR};
                  emit            = 1'b1;
               end
            end
         end
         dnsqp_pkg::PH_LABEL: begin
            nxt.name_section_length = length_inc;
            nxt.label_bytes_left    = cur.label_bytes_left - 8'd1;
            if (nxt.label_bytes_left == 8'd0) begin
               nxt.phase = dnsqp_pkg::PH_LENGTH;
            end
            rsp.field_kind  = dnsqp_pkg::KIND_NAME_CHAR;
            rsp.field_value = {8'h00, req.data_byte};
            emit            = 1'b1;
         end
         dnsqp_pkg::PH_QTYPE, dnsqp_pkg::PH_QCLASS: begin
            if (cur.byte_index == 4'd0) begin
               nxt.held_high_byte = req.data_byte;
               nxt.byte_index     = 4'd1;
            end else begin
               nxt.byte_index  = 4'd0;
               rsp.field_value = word;
               emit            = 1'b1;
               if (cur.phase == dnsqp_pkg::PH_QTYPE) begin
                  nxt.phase      = dnsqp_pkg::PH_QCLASS;
                  rsp.field_kind = dnsqp_pkg::KIND_QTYPE;
               end else begin
                  nxt.phase      = dnsqp_pkg::PH_IDLE;
                  rsp.field_kind = dnsqp_pkg::KIND_QCLASS;
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   assign state_next = nxt;

endmodule

`default_nettype wire

// File: rtl/dns_query_header_question_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload                          Transfer
// req      in         data_byte, start_of_message      req_valid & req_ready
// rsp      out        field_kind, field_value          rsp_valid & rsp_ready
//
// Each accepted byte is parsed in the cycle it is accepted; its result, if
// any, appears in the output register on the next cycle. One byte per cycle
// is sustained, limited only by the single output register.
// Reset is synchronous and active high; it places the parser at the first
// header byte with an empty output register.
// While a result waits in the output register and rsp_ready is low, the
// block stops taking bytes, including bytes that would give no result.
module dns_query_header_question_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dnsqp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dnsqp_pkg::rsp_type rsp_data
);

   // Running parse state, updated once per accepted transaction.
   dnsqp_pkg::parse_state_type state_ff;
   dnsqp_pkg::parse_state_type state_in;

   // Output register holding the pending result transaction.
   logic               rsp_valid_ff;
   dnsqp_pkg::rsp_type rsp_data_ff;

   logic               step_emit;
   dnsqp_pkg::rsp_type step_rsp;
   logic               req_fire;

   dnsqp_step u_step (
      .state_cur  (state_ff),
      .req        (req_data),
      .state_next (state_in),
      .emit       (step_emit),
      .rsp        (step_rsp)
   );

   // The output register can take a new result when it is empty or is
   // being drained in this same cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnsqp_pkg::STATE_RESTART;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (req_fire && step_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire && step_emit) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A pending result always carries one of the defined kinds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.field_kind <= dnsqp_pkg::KIND_QCLASS))
      else $error("result kind out of range");

   // Name characters are single bytes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.field_kind == dnsqp_pkg::KIND_NAME_CHAR)
      |-> (rsp_data_ff.field_value[15:8] == 8'h00))
      else $error("name character wider than a byte");

   // Inside a label at least one character is still due.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == dnsqp_pkg::PH_LABEL) |-> (state_ff.label_bytes_left != 8'd0))
      else $error("label phase with no characters left");

   // The header position never runs past the last header byte.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == dnsqp_pkg::PH_HEADER)
      |-> (state_ff.byte_index <= dnsqp_pkg::HEADER_LAST_INDEX))
      else $error("header byte index out of range");
`endif

endmodule

`default_nettype wire
